// ----- hw/rtl/rdsl_pkg.sv -----
// rdsl_pkg: widths, register indexes, reset values and shared types of the
// roi depth spatial locator. no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rdsl_pkg;

  localparam int DEPTH_W    = 16;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 10;
  localparam int SUM_W      = 36;
  localparam int CNT_W      = 20;
  localparam int COORD_W    = 17;
  localparam int SCALE_W    = 24;
  // frame positions up to 8191 and signed centre offsets
  localparam int POS_W      = 13;
  localparam int OFF_W      = 14;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int FRAME_WIDTH_DEF  = 1280;
  localparam int FRAME_HEIGHT_DEF = 720;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [DEPTH_W-1:0] MIN_START = 16'd50000;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_T_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_T_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd7;

  localparam logic [COL_W-1:0]   RST_X_MIN  = 11'd0;
  localparam logic [COL_W-1:0]   RST_X_MAX  = 11'd1279;
  localparam logic [ROW_W-1:0]   RST_Y_MIN  = 10'd0;
  localparam logic [ROW_W-1:0]   RST_Y_MAX  = 10'd719;
  localparam logic [DEPTH_W-1:0] RST_T_LOW  = 16'd100;
  localparam logic [DEPTH_W-1:0] RST_T_HIGH = 16'd50000;
  localparam logic [SCALE_W-1:0] RST_SCALE  = 24'd19574;

  localparam logic MODE_MEAN = 1'b0;
  localparam logic MODE_MIN  = 1'b1;

  // settings as seen by the datapath: bounds already clamped to the frame
  typedef struct packed {
    logic [POS_W-1:0]         x_min;
    logic [POS_W-1:0]         x_max;
    logic [POS_W-1:0]         y_min;
    logic [POS_W-1:0]         y_max;
    logic [DEPTH_W-1:0]       t_low;
    logic [DEPTH_W-1:0]       t_high;
    logic                     mode;
    logic [SCALE_W-1:0]       scale;
    logic signed [OFF_W-1:0]  off_x;
    logic signed [OFF_W-1:0]  off_y;
  } cfg_t;

  // per-frame totals handed from the front to the back
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   count;
    logic [DEPTH_W-1:0] min;
  } acc_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rdsl_fifo.sv -----
// rdsl_fifo: short register queue of frame totals between front and back.
// no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module rdsl_fifo #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> !empty)
    else $error("queue lost an item");

endmodule
`default_nettype wire

// ----- hw/rtl/rdsl_front.sv -----
// rdsl_front: roi and threshold test per pixel, running sum, count, minimum.
// depends on rdsl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rdsl_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rdsl_pkg::cfg_t                cfg,
  input  wire logic                          accept,
  input  wire logic [rdsl_pkg::DEPTH_W-1:0]  depth_value,
  input  wire logic [rdsl_pkg::COL_W-1:0]    pixel_col,
  input  wire logic [rdsl_pkg::ROW_W-1:0]    pixel_row,
  input  wire logic                          frame_end,
  output logic                               push,
  output rdsl_pkg::acc_t                     snap
);

  localparam int PW = rdsl_pkg::POS_W;

  rdsl_pkg::acc_t acc;
  logic [PW-1:0] col_ext;
  logic [PW-1:0] row_ext;
  logic in_roi;
  logic passes;
  logic hit;
  logic [rdsl_pkg::SUM_W:0] sum_wide;

  always_comb begin
    col_ext  = PW'(pixel_col);
    row_ext  = PW'(pixel_row);
    in_roi   = (col_ext >= cfg.x_min) && (col_ext < cfg.x_max) &&
               (row_ext >= cfg.y_min) && (row_ext < cfg.y_max);
    passes   = (depth_value > cfg.t_low) && (depth_value < cfg.t_high);
    hit      = in_roi && passes;
    sum_wide = {1'b0, acc.sum} + (rdsl_pkg::SUM_W + 1)'(depth_value);
    snap     = acc;
    if (hit) begin
      if (acc.count != '1) begin
        snap.count = acc.count + 1'b1;
      end
      // saturate at all ones
      snap.sum = sum_wide[rdsl_pkg::SUM_W] ? '1 : sum_wide[rdsl_pkg::SUM_W-1:0];
      if (depth_value < acc.min) begin
        snap.min = depth_value;
      end
    end
  end

  assign push = accept && frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc.sum   <= '0;
      acc.count <= '0;
      acc.min   <= rdsl_pkg::MIN_START;
    end else if (accept) begin
      if (frame_end) begin
        acc.sum   <= '0;
        acc.count <= '0;
        acc.min   <= rdsl_pkg::MIN_START;
      end else begin
        acc <= snap;
      end
    end
  end

  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    acc.min <= rdsl_pkg::MIN_START)
    else $error("minimum above start value");
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    push |=> acc.count == '0 && acc.sum == '0)
    else $error("totals not cleared after frame end");
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(acc.count))
    else $error("count moved without an item");

endmodule
`default_nettype wire

// ----- hw/rtl/rdsl_back.sv -----
// rdsl_back: minimum, or mean by iterative division, then scaling of the roi centre
// offsets and the result register. depends on rdsl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rdsl_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire rdsl_pkg::cfg_t                    cfg,
  input  wire logic                              empty,
  input  wire rdsl_pkg::acc_t                    head,
  output logic                                   pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [rdsl_pkg::DEPTH_W-1:0]           out_z,
  output logic [rdsl_pkg::COORD_W-1:0]           out_x,
  output logic [rdsl_pkg::COORD_W-1:0]           out_y,
  output logic [rdsl_pkg::CNT_W-1:0]             out_count
);

  localparam int DW     = rdsl_pkg::DEPTH_W;
  localparam int CW     = rdsl_pkg::CNT_W;
  localparam int STEP_W = $clog2(DW);
  localparam int PX_W   = DW + 1 + rdsl_pkg::OFF_W;
  localparam int PP_W   = PX_W + rdsl_pkg::SCALE_W + 1;
  localparam int FRAC   = rdsl_pkg::SCALE_W;
  localparam int V_W    = PP_W - FRAC + 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL1 = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state;
  rdsl_pkg::acc_t snap;
  logic [DW-1:0] z;
  logic [CW-1:0] rem;
  logic [DW-1:0] num;
  logic [DW-1:0] quo;
  logic [STEP_W-1:0] step;
  logic signed [PX_W-1:0] px;
  logic signed [PX_W-1:0] py;
  logic signed [PP_W-1:0] ppx;
  logic signed [PP_W-1:0] ppy;
  logic [CW+1:0] diff;
  logic ge;
  logic too_big;

  // truncate toward zero after the q0.24 product, optional negate, saturate
  function automatic logic [rdsl_pkg::COORD_W-1:0] to_coord(
    input logic signed [PP_W-1:0] p,
    input logic neg
  );
    logic signed [V_W-1:0] v;
    v = {p[PP_W-1], p[PP_W-1:FRAC]};
    if (p[PP_W-1] && (p[FRAC-1:0] != '0)) begin
      v = v + V_W'(1);
    end
    if (neg) begin
      v = -v;
    end
    if (v > V_W'(65535)) begin
      v = V_W'(65535);
    end else if (v < -V_W'(65536)) begin
      v = -V_W'(65536);
    end
    return v[rdsl_pkg::COORD_W-1:0];
  endfunction

  always_comb begin
    diff    = {1'b0, rem, num[DW-1]} - {2'b00, snap.count};
    ge      = !diff[CW+1];
    too_big = ({head.count, {DW{1'b0}}} <= head.sum);
  end

  assign pop = (state == ST_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if ((state == ST_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            if ((cfg.mode == rdsl_pkg::MODE_MIN) || (head.count == '0) || too_big) begin
              state <= ST_MUL1;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (step == STEP_W'(DW - 1)) begin
            state <= ST_MUL1;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_FIN;
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        snap <= head;
        rem  <= head.sum[rdsl_pkg::SUM_W-1:DW];
        num  <= head.sum[DW-1:0];
        quo  <= '0;
        if (cfg.mode == rdsl_pkg::MODE_MIN) begin
          z <= head.min;
        end else if (head.count == '0) begin
          z <= '0;
        end else if (too_big) begin
          z <= '1;
        end
      end
      ST_DIV: begin
        rem <= ge ? diff[CW-1:0] : {rem[CW-2:0], num[DW-1]};
        num <= {num[DW-2:0], 1'b0};
        quo <= {quo[DW-2:0], ge};
        if (step == STEP_W'(DW - 1)) begin
          z <= {quo[DW-2:0], ge};
        end
      end
      ST_MUL1: begin
        px <= $signed({1'b0, z}) * cfg.off_x;
        py <= $signed({1'b0, z}) * cfg.off_y;
      end
      ST_MUL2: begin
        ppx <= px * $signed({1'b0, cfg.scale});
        ppy <= py * $signed({1'b0, cfg.scale});
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          out_z     <= z;
          out_x     <= to_coord(ppx, 1'b0);
          out_y     <= to_coord(ppy, 1'b1);
          out_count <= snap.count;
        end
      end
      default: begin
      end
    endcase
  end

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < snap.count)
    else $error("division remainder out of range");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && step == STEP_W'(DW - 1) |=> state == ST_MUL1)
    else $error("division did not finish after its last step");
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_valid && !out_ready |=> state == ST_FIN)
    else $error("result dropped while output stalled");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != ST_IDLE)
    else $error("frame totals taken without processing");

endmodule
`default_nettype wire

// ----- hw/rtl/roi_depth_spatial_locator_top.sv -----
// roi_depth_spatial_locator_top: stream ports, settings registers, front,
// queue and back. depends on rdsl_pkg, rdsl_front, rdsl_fifo, rdsl_back.
`timescale 1ns / 1ps
`default_nettype none
// Depth pixels enter on s_axis one per clock cycle while s_axis_tready is
// high; each pixel inside the ROI whose depth lies strictly between the
// thresholds adds to a running sum, count and minimum. The pixel with tlast
// high closes the frame: its totals go into a two-entry queue and the
// accumulators restart, so the next frame can stream in at once. The back
// end turns each queued frame into one item on m_axis: the depth is set
// directly (minimum mode, empty or saturating mean) or computed by a
// 16-step shift-subtract divider (mean), then two registered multiplies
// for x and y feed the result register. s_axis_tready drops only while the
// queue holds two unfinished frames. ROI bounds are clamped to the frame
// size; settings are to be written between frames, while no result is
// pending.
module roi_depth_spatial_locator_top #(
  parameter int FRAME_WIDTH  = rdsl_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rdsl_pkg::FRAME_HEIGHT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // depth_value [15:0], pixel_col [26:16], pixel_row [36:27], zero fill
  input  wire logic [rdsl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // depth_z [15:0], coord_x [32:16], coord_y [49:33], valid_count [69:50]
  output logic [rdsl_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rdsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rdsl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PW = rdsl_pkg::POS_W;
  localparam int OW = rdsl_pkg::OFF_W;
  localparam logic [PW-1:0] X_TOP  = PW'(FRAME_WIDTH - 1);
  localparam logic [PW-1:0] Y_TOP  = PW'(FRAME_HEIGHT - 1);
  localparam logic signed [OW-1:0] X_HALF = OW'(FRAME_WIDTH / 2);
  localparam logic signed [OW-1:0] Y_HALF = OW'(FRAME_HEIGHT / 2);

  // settings registers
  logic [rdsl_pkg::COL_W-1:0]   roi_x_min;
  logic [rdsl_pkg::COL_W-1:0]   roi_x_max;
  logic [rdsl_pkg::ROW_W-1:0]   roi_y_min;
  logic [rdsl_pkg::ROW_W-1:0]   roi_y_max;
  logic [rdsl_pkg::DEPTH_W-1:0] thresh_low;
  logic [rdsl_pkg::DEPTH_W-1:0] thresh_high;
  logic                         depth_mode;
  logic [rdsl_pkg::SCALE_W-1:0] angle_scale;
  logic signed [OW-1:0]         off_x;
  logic signed [OW-1:0]         off_y;

  rdsl_pkg::cfg_t cfg;
  rdsl_pkg::acc_t snap;
  rdsl_pkg::acc_t head;
  logic s_accept;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  logic [rdsl_pkg::DEPTH_W-1:0] out_z;
  logic [rdsl_pkg::COORD_W-1:0] out_x;
  logic [rdsl_pkg::COORD_W-1:0] out_y;
  logic [rdsl_pkg::CNT_W-1:0]   out_count;

  // centre offset of [lo, hi) from the frame centre, halving toward zero
  function automatic logic signed [OW-1:0] centre_off(
    input logic [PW-1:0] lo,
    input logic [PW-1:0] hi,
    input logic signed [OW-1:0] half
  );
    logic signed [OW-1:0] span;
    logic signed [OW-1:0] mid;
    span = $signed(OW'(hi)) - $signed(OW'(lo));
    mid  = ((span + $signed(OW'(span[OW-1]))) >>> 1) + $signed(OW'(lo));
    return mid - half;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_x_min   <= rdsl_pkg::RST_X_MIN;
      roi_x_max   <= rdsl_pkg::RST_X_MAX;
      roi_y_min   <= rdsl_pkg::RST_Y_MIN;
      roi_y_max   <= rdsl_pkg::RST_Y_MAX;
      thresh_low  <= rdsl_pkg::RST_T_LOW;
      thresh_high <= rdsl_pkg::RST_T_HIGH;
      depth_mode  <= rdsl_pkg::MODE_MEAN;
      angle_scale <= rdsl_pkg::RST_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rdsl_pkg::REG_X_MIN:  roi_x_min   <= cfg_data[rdsl_pkg::COL_W-1:0];
        rdsl_pkg::REG_X_MAX:  roi_x_max   <= cfg_data[rdsl_pkg::COL_W-1:0];
        rdsl_pkg::REG_Y_MIN:  roi_y_min   <= cfg_data[rdsl_pkg::ROW_W-1:0];
        rdsl_pkg::REG_Y_MAX:  roi_y_max   <= cfg_data[rdsl_pkg::ROW_W-1:0];
        rdsl_pkg::REG_T_LOW:  thresh_low  <= cfg_data[rdsl_pkg::DEPTH_W-1:0];
        rdsl_pkg::REG_T_HIGH: thresh_high <= cfg_data[rdsl_pkg::DEPTH_W-1:0];
        rdsl_pkg::REG_MODE:   depth_mode  <= cfg_data[0];
        rdsl_pkg::REG_SCALE:  angle_scale <= cfg_data[rdsl_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // bounds clamped to the last column and row
  always_comb begin
    cfg.x_min  = (PW'(roi_x_min) > X_TOP) ? X_TOP : PW'(roi_x_min);
    cfg.x_max  = (PW'(roi_x_max) > X_TOP) ? X_TOP : PW'(roi_x_max);
    cfg.y_min  = (PW'(roi_y_min) > Y_TOP) ? Y_TOP : PW'(roi_y_min);
    cfg.y_max  = (PW'(roi_y_max) > Y_TOP) ? Y_TOP : PW'(roi_y_max);
    cfg.t_low  = thresh_low;
    cfg.t_high = thresh_high;
    cfg.mode   = depth_mode;
    cfg.scale  = angle_scale;
    cfg.off_x  = off_x;
    cfg.off_y  = off_y;
  end

  // offsets are only used in the back end's multiplies after a frame end, so register them
  always_ff @(posedge clk) begin
    off_x <= centre_off(cfg.x_min, cfg.x_max, X_HALF);
    off_y <= centre_off(cfg.y_min, cfg.y_max, Y_HALF);
  end

  assign s_axis_tready = !q_full;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  rdsl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (s_accept),
    .depth_value (s_axis_tdata[15:0]),
    .pixel_col   (s_axis_tdata[26:16]),
    .pixel_row   (s_axis_tdata[36:27]),
    .frame_end   (s_axis_tlast),
    .push        (push),
    .snap        (snap)
  );

  rdsl_fifo #(
    .WIDTH ($bits(rdsl_pkg::acc_t)),
    .DEPTH (rdsl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (snap),
    .pop   (pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  rdsl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_z     (out_z),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_count (out_count)
  );

  assign m_axis_tdata = {2'b00, out_count, out_y, out_x, out_z};

endmodule
`default_nettype wire
